@@ hdl/tilemap_box_collision_check_macros.svh @@
// assertion macros used by the tile map collision check sequencer
`ifndef TILEMAP_BOX_COLLISION_CHECK_MACROS_SVH
`define TILEMAP_BOX_COLLISION_CHECK_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define TBCC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// condition must never be seen outside reset
`define TBCC_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define TBCC_ASSERT(label, prop, msg)
`define TBCC_ASSERT_NEVER(label, cond, msg)
`endif
`endif

@@ hdl/tbcc_pkg.sv @@
// shared types and constants of the tile map collision check
package tbcc_pkg;

   // tile store geometry, depth is a power of two
   localparam int TILE_STORE_DEPTH = 4096;
   localparam int STORE_ADDR_W     = $clog2(TILE_STORE_DEPTH);
   localparam int TILE_W           = 8;
   localparam int LIN_W            = 16;
   localparam int WIDX_W           = 12;
   localparam int PIXEL_W          = 16;
   localparam int SIZE_W           = 8;
   localparam int TILE_SHIFT       = 3;

   // tile value that always counts as solid
   localparam logic [TILE_W-1:0] TILE_OUT_OF_MAP = 8'hFF;

   // item modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_WIDTH       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_HEIGHT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOLID_THRESHOLD = 2'd2;

   // reset values of the registers
   localparam logic [TILE_W-1:0] RESET_MAP_WIDTH       = 8'd32;
   localparam logic [TILE_W-1:0] RESET_MAP_HEIGHT      = 8'd30;
   localparam logic [TILE_W-1:0] RESET_SOLID_THRESHOLD = 8'd128;

   typedef struct packed {
      logic [TILE_W-1:0] map_width;
      logic [TILE_W-1:0] map_height;
      logic [TILE_W-1:0] solid_threshold;
   } tbcc_cfg_type;

   // finished item handed to the output register
   typedef struct packed {
      logic valid;
      logic solid;
   } tbcc_result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_CORNER,
      ST_LAST,
      ST_DONE
   } tbcc_state_type;

   // pixel coordinate to tile coordinate, low byte only
   function automatic logic [TILE_W-1:0] pixel_to_tile(input logic [PIXEL_W-1:0] px);
      pixel_to_tile = px[TILE_SHIFT +: TILE_W];
   endfunction

endpackage

@@ hdl/tbcc_tile_ram.sv @@
// single port synchronous ram holding the tile map
module tbcc_tile_ram #(
   parameter int DEPTH  = 4096,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  write_data,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write or read one entry per cycle, read data registered
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[addr] <= write_data;
      end else begin
         read_data_ff <= mem[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ hdl/tbcc_seq.sv @@
// item sequencer: tile writes, corner address generation, tile reads and solidity check
module tbcc_seq
   import tbcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  tbcc_cfg_type        cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [WIDX_W-1:0]   req_write_index,
   input  logic [TILE_W-1:0]   req_tile_value,
   input  logic [PIXEL_W-1:0]  req_world_x,
   input  logic [PIXEL_W-1:0]  req_world_y,
   input  logic [SIZE_W-1:0]   req_box_width,
   input  logic [SIZE_W-1:0]   req_box_height,
   input  logic                result_hold,
   output tbcc_result_type     result
);

`include "tilemap_box_collision_check_macros.svh"

   tbcc_state_type state_ff, state_in;

   logic [1:0]              corner_ff, corner_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic                    oob_ff, oob_in;
   logic                    hit_ff, hit_in;
   logic [TILE_W-1:0]       tx1_ff, tx2_ff, ty1_ff, ty2_ff;
   logic [STORE_ADDR_W-1:0] waddr_ff;
   logic [TILE_W-1:0]       wdata_ff;

   logic                    accept;
   logic                    rd_issue;
   logic                    ram_we;
   logic [STORE_ADDR_W-1:0] ram_addr;
   logic [TILE_W-1:0]       ram_rdata;
   logic [PIXEL_W-1:0]      far_x, far_y;
   logic [TILE_W-1:0]       cur_tx, cur_ty;
   logic [LIN_W-1:0]        lin;
   logic [LIN_W-1:0]        widx_wide;
   logic                    cur_oob;
   logic                    tile_solid;

   assign accept = req_valid && !req_stall;

   // far corner with 16-bit wrap
   assign far_x = req_world_x + PIXEL_W'(req_box_width) - PIXEL_W'(1);
   assign far_y = req_world_y + PIXEL_W'(req_box_height) - PIXEL_W'(1);

   // corner select: bit 0 picks far x, bit 1 picks far y
   assign cur_tx  = corner_ff[0] ? tx2_ff : tx1_ff;
   assign cur_ty  = corner_ff[1] ? ty2_ff : ty1_ff;
   assign cur_oob = (cur_tx >= cfg.map_width) || (cur_ty >= cfg.map_height);
   assign lin     = LIN_W'(cur_ty) * LIN_W'(cfg.map_width) + LIN_W'(cur_tx);

   assign widx_wide = LIN_W'(req_write_index);

   // tile read back from the previous cycle
   assign tile_solid = oob_ff || (ram_rdata == TILE_OUT_OF_MAP)
                       || (ram_rdata >= cfg.solid_threshold);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_mode == MODE_WRITE) ? ST_WRITE : ST_CORNER;
            end
         end
         ST_WRITE:  state_in = ST_DONE;
         ST_CORNER: begin
            if (corner_ff == 2'd3) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST:   state_in = ST_DONE;
         ST_DONE: begin
            if (!result_hold) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_stall    = 1'b1;
      ram_we       = 1'b0;
      rd_issue     = 1'b0;
      result.valid = 1'b0;
      result.solid = hit_ff;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_WRITE:  ram_we = 1'b1;
         ST_CORNER: rd_issue = 1'b1;
         ST_LAST:   ;
         ST_DONE:   result.valid = !result_hold;
         default:   ;
      endcase
   end

   assign ram_addr = ram_we ? waddr_ff : lin[STORE_ADDR_W-1:0];

   // corner counter, read pipeline and hit accumulation
   always_comb begin
      corner_in  = rd_issue ? corner_ff + 2'd1 : corner_ff;
      rd_pend_in = rd_issue;
      oob_in     = cur_oob;
      hit_in     = hit_ff || (rd_pend_ff && tile_solid);
      if (accept) begin
         corner_in = 2'd0;
         hit_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         corner_ff  <= 2'd0;
         rd_pend_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         corner_ff  <= corner_in;
         rd_pend_ff <= rd_pend_in;
         hit_ff     <= hit_in;
      end
   end

   // item payload captured on accept
   always_ff @(posedge clock) begin
      oob_ff <= oob_in;
      if (accept) begin
         tx1_ff   <= pixel_to_tile(req_world_x);
         tx2_ff   <= pixel_to_tile(far_x);
         ty1_ff   <= pixel_to_tile(req_world_y);
         ty2_ff   <= pixel_to_tile(far_y);
         waddr_ff <= widx_wide[STORE_ADDR_W-1:0];
         wdata_ff <= req_tile_value;
      end
   end

   tbcc_tile_ram #(
      .DEPTH (TILE_STORE_DEPTH),
      .WIDTH (TILE_W)
   ) u_tile_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .addr         (ram_addr),
      .write_data   (wdata_ff),
      .read_data    (ram_rdata)
   );

   `TBCC_ASSERT(a_accept_leaves_idle, accept |=> (state_ff != ST_IDLE), "accept did not start item")
   `TBCC_ASSERT_NEVER(a_done_with_pending_read, (state_ff == ST_DONE) && rd_pend_ff, "result before last tile read")
   `TBCC_ASSERT(a_write_reports_clear, (state_ff == ST_WRITE) |-> !hit_ff, "write item carries a hit")
   `TBCC_ASSERT(a_last_follows_fourth_read, (state_ff == ST_LAST) |-> (rd_pend_ff && $past(corner_ff) == 2'd3), "fourth corner not read")

endmodule

@@ hdl/tilemap_box_collision_check.sv @@
// top level of the tile map box collision check
//
// Keeps a 4096-entry byte tile map in one single-port synchronous RAM and
// answers one result item for every request item. A write item stores a tile
// byte. A query item reads its four box corners one per cycle through the
// single RAM port, then evaluates the last read; the next item can be taken
// the cycle after its result. The result waits in an output register, so a
// stalled result holds the block only once the next item is finished. The
// store has no reset; every tile a query can reach must be written first.
// Configuration registers must be written only while the block is idle; the
// block itself does not enforce this.
module tilemap_box_collision_check
   import tbcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TILE_W-1:0]      csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [WIDX_W-1:0]      req_write_index,
   input  logic [TILE_W-1:0]      req_tile_value,
   input  logic [PIXEL_W-1:0]     req_world_x,
   input  logic [PIXEL_W-1:0]     req_world_y,
   input  logic [SIZE_W-1:0]      req_box_width,
   input  logic [SIZE_W-1:0]      req_box_height,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_solid
);

   tbcc_cfg_type    cfg_ff, cfg_in;
   tbcc_result_type result;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_solid_ff;
   logic            result_hold;

   // configuration register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:       cfg_in.map_width       = csr_write_data;
            CSR_MAP_HEIGHT:      cfg_in.map_height      = csr_write_data;
            CSR_SOLID_THRESHOLD: cfg_in.solid_threshold = csr_write_data;
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width       <= RESET_MAP_WIDTH;
         cfg_ff.map_height      <= RESET_MAP_HEIGHT;
         cfg_ff.solid_threshold <= RESET_SOLID_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // output register is full and not taken this cycle
   assign result_hold = rsp_valid_ff && rsp_stall;

   tbcc_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_write_index (req_write_index),
      .req_tile_value  (req_tile_value),
      .req_world_x     (req_world_x),
      .req_world_y     (req_world_y),
      .req_box_width   (req_box_width),
      .req_box_height  (req_box_height),
      .result_hold     (result_hold),
      .result          (result)
   );

   // result output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_solid_ff <= result.solid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_solid = rsp_solid_ff;

endmodule

@@ test/tbcc_checker.sv @@
`timescale 1ns / 100ps
// result checker of the tile map collision check: watches both channels, predicts and compares
module tbcc_checker
   import tbcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TILE_W-1:0]      csr_write_data,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_mode,
   input  logic [WIDX_W-1:0]      req_write_index,
   input  logic [TILE_W-1:0]      req_tile_value,
   input  logic [PIXEL_W-1:0]     req_world_x,
   input  logic [PIXEL_W-1:0]     req_world_y,
   input  logic [SIZE_W-1:0]      req_box_width,
   input  logic [SIZE_W-1:0]      req_box_height,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_solid,
   output int                     error_count,
   output int                     pending_count,
   output int                     solid_count
);

   localparam int REPORT_LIMIT = 10;

   // shadow copy of the tile map and the registers
   logic [TILE_W-1:0] tile_copy [TILE_STORE_DEPTH];
   tbcc_cfg_type      cfg_copy;

   // solidity flags of accepted items, oldest first
   bit   solid_expected [$];
   int   result_index;

   initial begin
      error_count   = 0;
      pending_count = 0;
      solid_count   = 0;
      result_index  = 0;
   end

   // one corner: outside the map, an always-solid tile, or at or above threshold
   function automatic bit corner_hits(input logic [PIXEL_W-1:0] px, input logic [PIXEL_W-1:0] py);
      logic [TILE_W-1:0] tx;
      logic [TILE_W-1:0] ty;
      logic [LIN_W-1:0]  lin;
      logic [TILE_W-1:0] tile;
      tx = TILE_W'(px >> TILE_SHIFT);
      ty = TILE_W'(py >> TILE_SHIFT);
      if (tx >= cfg_copy.map_width || ty >= cfg_copy.map_height)
         return 1'b1;
      lin  = LIN_W'({8'd0, ty} * {8'd0, cfg_copy.map_width} + {8'd0, tx});
      tile = tile_copy[lin[STORE_ADDR_W-1:0]];
      return (tile == TILE_OUT_OF_MAP) || (tile >= cfg_copy.solid_threshold);
   endfunction

   // far corner wraps at 16 bits, box is solid if any corner is
   function automatic bit box_is_solid(input logic [PIXEL_W-1:0] x, input logic [PIXEL_W-1:0] y,
                                       input logic [SIZE_W-1:0] bw, input logic [SIZE_W-1:0] bh);
      logic [PIXEL_W-1:0] x2;
      logic [PIXEL_W-1:0] y2;
      x2 = x + {8'd0, bw} - 16'd1;
      y2 = y + {8'd0, bh} - 16'd1;
      return corner_hits(x, y) || corner_hits(x2, y) || corner_hits(x, y2) || corner_hits(x2, y2);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_copy.map_width       = RESET_MAP_WIDTH;
         cfg_copy.map_height      = RESET_MAP_HEIGHT;
         cfg_copy.solid_threshold = RESET_SOLID_THRESHOLD;
         solid_expected.delete();
      end else begin
         // compare a delivered result with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (solid_expected.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("unexpected result %0d: solid=%0b with no item waiting",
                           result_index, rsp_solid);
               error_count++;
            end else begin
               bit want;
               want = solid_expected.pop_front();
               if (rsp_solid !== want) begin
                  if (error_count < REPORT_LIMIT)
                     $display("mismatch on result %0d: expected solid=%0b, got %0b",
                              result_index, want, rsp_solid);
                  error_count++;
               end
               if (rsp_solid === 1'b1)
                  solid_count++;
            end
            result_index++;
         end

         // register writes, unknown indexes are dropped
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAP_WIDTH:       cfg_copy.map_width       = csr_write_data;
               CSR_MAP_HEIGHT:      cfg_copy.map_height      = csr_write_data;
               CSR_SOLID_THRESHOLD: cfg_copy.solid_threshold = csr_write_data;
               default: ;
            endcase
         end

         // accepted item: store a tile or evaluate a box
         if (req_valid && !req_stall) begin
            if (req_mode == MODE_WRITE) begin
               tile_copy[req_write_index[STORE_ADDR_W-1:0]] = req_tile_value;
               solid_expected.push_back(1'b0);
            end else begin
               solid_expected.push_back(box_is_solid(req_world_x, req_world_y,
                                                     req_box_width, req_box_height));
            end
         end
      end
      pending_count = solid_expected.size();
   end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// testbench top of the tile map collision check: stimulus, register phases and verdict
module tb;
   import tbcc_pkg::*;

   localparam int CYCLE_LIMIT      = 1000000;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int SETTLE_CYCLES    = 12;
   localparam int RANDOM_PER_PHASE = 34;
   localparam int PHASE_COUNT      = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [TILE_W-1:0]      csr_write_data   = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic                   req_mode         = MODE_WRITE;
   logic [WIDX_W-1:0]      req_write_index  = '0;
   logic [TILE_W-1:0]      req_tile_value   = '0;
   logic [PIXEL_W-1:0]     req_world_x      = '0;
   logic [PIXEL_W-1:0]     req_world_y      = '0;
   logic [SIZE_W-1:0]      req_box_width    = '0;
   logic [SIZE_W-1:0]      req_box_height   = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic                   rsp_solid;

   int error_count;
   int pending_count;
   int solid_count;

   // register values as last written, used to aim items at the map
   logic [TILE_W-1:0] cur_width  = RESET_MAP_WIDTH;
   logic [TILE_W-1:0] cur_height = RESET_MAP_HEIGHT;
   logic [TILE_W-1:0] cur_thresh = RESET_SOLID_THRESHOLD;

   // store entries that hold a tile, so no query reads an unwritten one
   bit written [TILE_STORE_DEPTH];

   bit hold_request   = 1'b0;
   int items_sent     = 0;
   int queries_sent   = 0;
   int settings_used  = 0;
   int quiet_left     = 0;
   int cycle_count    = 0;

   tilemap_box_collision_check i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_write_index  (req_write_index),
      .req_tile_value   (req_tile_value),
      .req_world_x      (req_world_x),
      .req_world_y      (req_world_y),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_solid        (rsp_solid)
   );

   tbcc_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_write_index  (req_write_index),
      .req_tile_value   (req_tile_value),
      .req_world_x      (req_world_x),
      .req_world_y      (req_world_y),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_solid        (rsp_solid),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .solid_count      (solid_count)
   );

   // clock
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // idle cycles before the next item: mostly none, some short, a few long
   function automatic int unsigned sender_gap();
      int unsigned r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // store entry read by a corner under the current map width
   function automatic int unsigned corner_slot(input logic [PIXEL_W-1:0] px,
                                               input logic [PIXEL_W-1:0] py);
      int unsigned tx;
      int unsigned ty;
      tx = (px >> TILE_SHIFT) & 32'hFF;
      ty = (py >> TILE_SHIFT) & 32'hFF;
      return ((ty * cur_width + tx) & 32'hFFFF) % TILE_STORE_DEPTH;
   endfunction

   // tile values spread around the threshold and the always-solid code
   function automatic logic [TILE_W-1:0] pick_tile();
      case ($urandom_range(0, 7))
         0, 1, 2: return (cur_thresh == 0) ? 8'd0 : TILE_W'($urandom_range(0, cur_thresh - 1));
         3:       return TILE_OUT_OF_MAP;
         4:       return cur_thresh;
         default: return TILE_W'($urandom());
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] box_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return SIZE_W'($urandom_range(1, 24));
      if (r < 90) return SIZE_W'($urandom_range(1, 255));
      if (r < 95) return 8'd0;
      return 8'd255;
   endfunction

   // pixel coordinate inside the map or just past its edge
   function automatic logic [PIXEL_W-1:0] near_coord(input logic [TILE_W-1:0] tiles);
      return PIXEL_W'($urandom_range(0, tiles * 8 + 24));
   endfunction

   // present one item and hold it until it is taken
   task automatic offer(input logic mode, input logic [WIDX_W-1:0] widx,
                        input logic [TILE_W-1:0] tval,
                        input logic [PIXEL_W-1:0] x, input logic [PIXEL_W-1:0] y,
                        input logic [SIZE_W-1:0] bw, input logic [SIZE_W-1:0] bh);
      int unsigned gap;
      bit          taken;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode        <= mode;
      req_write_index <= widx;
      req_tile_value  <= tval;
      req_world_x     <= x;
      req_world_y     <= y;
      req_box_width   <= bw;
      req_box_height  <= bh;
      req_valid       <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic put_tile(input int unsigned slot, input logic [TILE_W-1:0] value);
      offer(MODE_WRITE, WIDX_W'(slot), value, PIXEL_W'($urandom()), PIXEL_W'($urandom()),
            SIZE_W'($urandom()), SIZE_W'($urandom()));
      written[slot] = 1'b1;
   endtask

   // fill any corner entry not yet written, then ask about the box
   task automatic put_query(input logic [PIXEL_W-1:0] x, input logic [PIXEL_W-1:0] y,
                            input logic [SIZE_W-1:0] bw, input logic [SIZE_W-1:0] bh);
      logic [PIXEL_W-1:0] x2;
      logic [PIXEL_W-1:0] y2;
      int unsigned        slots [4];
      x2 = x + {8'd0, bw} - 16'd1;
      y2 = y + {8'd0, bh} - 16'd1;
      slots[0] = corner_slot(x, y);
      slots[1] = corner_slot(x2, y);
      slots[2] = corner_slot(x, y2);
      slots[3] = corner_slot(x2, y2);
      foreach (slots[i])
         if (!written[slots[i]])
            put_tile(slots[i], pick_tile());
      offer(MODE_QUERY, WIDX_W'($urandom()), TILE_W'($urandom()), x, y, bw, bh);
      queries_sent++;
   endtask

   task automatic random_item();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 22)
         put_tile($urandom_range(0, TILE_STORE_DEPTH - 1), pick_tile());
      else if (r < 32)
         put_tile(corner_slot(near_coord(cur_width), near_coord(cur_height)), pick_tile());
      else if (r < 90)
         put_query(near_coord(cur_width), near_coord(cur_height), box_size(), box_size());
      else
         put_query(PIXEL_W'($urandom()), PIXEL_W'($urandom()),
                   SIZE_W'($urandom()), SIZE_W'($urandom()));
   endtask

   // write all registers back to back, optionally poking the unused index
   task automatic apply_config(input logic [TILE_W-1:0] w, input logic [TILE_W-1:0] h,
                               input logic [TILE_W-1:0] thr, input bit poke_unused);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MAP_WIDTH;
      csr_write_data   <= w;
      @(posedge clock);
      csr_index        <= CSR_MAP_HEIGHT;
      csr_write_data   <= h;
      @(posedge clock);
      csr_index        <= CSR_SOLID_THRESHOLD;
      csr_write_data   <= thr;
      @(posedge clock);
      if (poke_unused) begin
         csr_index      <= CSR_UNUSED;
         csr_write_data <= TILE_W'($urandom());
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      cur_width  = w;
      cur_height = h;
      cur_thresh = thr;
      settings_used++;
   endtask

   // stop offering and wait until every result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // edge cases under the reset map of 32 by 30 tiles
   task automatic directed_items();
      put_tile(0, 8'd0);
      put_tile(1, 8'd127);
      put_tile(2, 8'd128);
      put_tile(3, TILE_OUT_OF_MAP);
      put_tile(TILE_STORE_DEPTH - 1, 8'hFF);
      put_query(16'd0, 16'd0, 8'd1, 8'd1);
      put_query(16'd8, 16'd0, 8'd1, 8'd1);
      put_query(16'd16, 16'd0, 8'd1, 8'd1);
      put_query(16'd24, 16'd0, 8'd1, 8'd1);
      put_query(16'd0, 16'd0, 8'd16, 8'd1);
      // tile coordinates past 255 wrap onto low tiles
      put_query(16'd2048, 16'd0, 8'd1, 8'd1);
      put_query(16'd0, 16'd2048, 8'd1, 8'd1);
      // zero size puts the far edge one pixel before the origin
      put_query(16'd0, 16'd0, 8'd0, 8'd0);
      put_query(16'd40, 16'd40, 8'd0, 8'd5);
      // far corner wraps at 16 bits
      put_query(16'hFFFF, 16'hFFFF, 8'd1, 8'd1);
      put_query(16'hFFFF, 16'd0, 8'd2, 8'd1);
      put_query(16'd0, 16'd0, 8'd255, 8'd255);
      put_query(16'd248, 16'd0, 8'd8, 8'd8);
      put_query(16'd256, 16'd0, 8'd1, 8'd1);
      put_query(16'd0, 16'd232, 8'd1, 8'd8);
   endtask

   // receiver stall: random runs, with one long hold-off on request
   initial begin
      int          run_left;
      bit          run_stall;
      int unsigned r;
      run_left  = 0;
      run_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            run_stall    = 1'b1;
            run_left     = HOLD_OFF_CYCLES;
         end else if (run_left <= 0) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
               run_stall = 1'b0;
               run_left  = $urandom_range(50, 150);
            end else if (r < 60) begin
               run_stall = 1'b0;
               run_left  = $urandom_range(1, 6);
            end else if (r < 92) begin
               run_stall = 1'b1;
               run_left  = $urandom_range(1, 3);
            end else begin
               run_stall = 1'b1;
               run_left  = $urandom_range(8, 40);
            end
         end
         rsp_stall <= run_stall;
         run_left--;
      end
   end

   // reset, register phases, stimulus and verdict
   initial begin
      int phase;
      int i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            drain_results();
            case (phase)
               1: apply_config(8'd255, 8'd255, 8'd255, 1'b1);
               2: apply_config(8'd0, 8'd0, 8'd0, 1'b0);
               3: apply_config(8'd64, 8'd64, 8'd1, 1'b0);
               4: apply_config(TILE_W'($urandom_range(1, 80)), TILE_W'($urandom_range(0, 80)),
                               TILE_W'($urandom()), 1'b1);
               default: apply_config(TILE_W'($urandom_range(1, 80)),
                                     TILE_W'($urandom_range(1, 80)),
                                     TILE_W'($urandom()), 1'b0);
            endcase
         end
         if (phase == 0)
            directed_items();
         for (i = 0; i < RANDOM_PER_PHASE; i++) begin
            // long receiver hold-off while items keep coming
            if (phase == 0 && i == 10)
               hold_request = 1'b1;
            random_item();
         end
      end
      drain_results();
      $display("run covered %0d items, %0d of them box queries, over %0d register settings",
               items_sent, queries_sent, settings_used + 1);
      $display("%0d results reported a solid box, %0d mismatches", solid_count, error_count);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
